// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the GPIO port engine checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of clk while arst_n is high.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every rising edge of clk, reset included.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/gpre_pkg.sv -----
// ----------------------------------------------------------------------------
// GPIO port engine package
// Command codes, the command item, the per-port register word and the
// control group passed between the command unit and the line router.
// ----------------------------------------------------------------------------
`default_nettype none

package gpre_pkg;

	// Command codes carried in the input tuser.
	typedef enum logic [2:0] {
		CMD_GET    = 3'd0,
		CMD_SET    = 3'd1,
		CMD_CONFIG = 3'd2,
		CMD_IRQ    = 3'd3,
		CMD_DELAY  = 3'd4
	} cmd_t;

	// One command item; the command code sits in the lowest bits.
	typedef struct packed {
		logic        rising_edge;
		logic        irq_enable;
		logic [1:0]  pull;
		logic [1:0]  speed;
		logic        open_drain;
		logic [3:0]  alt_func;
		logic [1:0]  mode;
		logic [15:0] value;
		logic [15:0] mask;
		logic [3:0]  pin;
		logic [2:0]  port;
		cmd_t        cmd;
	} item_t;

	// All registers of one port, held as one memory word.
	typedef struct packed {
		logic [15:0] out_levels;
		logic [63:0] altfunc;
		logic [31:0] pull;
		logic [31:0] speed;
		logic [15:0] otype;
		logic [31:0] mode;
	} port_word_t;

	// Decisions taken by the command unit for one item.
	typedef struct packed {
		logic wr_en;
		logic err;
		logic clk_en;
		logic irq_en;
	} ctl_t;

	localparam int ITEM_W = $bits(item_t);

	// Pin mode code that selects the output latch on a read.
	localparam logic [1:0] MODE_OUTPUT = 2'b01;

	// Clock enable bit used by each port.
	localparam logic [2:0] CLK_BIT_OF_PORT [8] = '{
		3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd6, 3'd7, 3'd5
	};

endpackage

`default_nettype wire

// ----- rtl/core/gpio_port_register_engine_core.sv -----
// Read path: the memory read started at the command transfer edge is ready in
// stage one; the result enters the output register as stage one advances.
// Throughput: one command per cycle unless the output register stalls, via the
// single read-modify-write path of the port memory, with forwarding of a word
// written back at the read edge.
// Reset: asynchronous; clears valid bits, clock enables and line router at once.
// ----------------------------------------------------------------------------
// GPIO port register engine
// Command stream in, one result per command out; port registers live in a
// one-word-per-port memory read in stage one and written back on issue.
// ----------------------------------------------------------------------------
`default_nettype none

module gpio_port_register_engine_core
	import gpre_pkg::*;
#(
	parameter int NUM_PORTS     = 8,
	parameter int PINS_PER_PORT = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// port[2:0], pin[6:3], mask[22:7], value[38:23], mode[40:39],
	// alt_func[44:41], open_drain[45], speed[47:46], pull[49:48],
	// irq_enable[50], rising_edge[51], zero padding[55:52]
	input  wire logic [55:0] s_tdata,
	// cmd[2:0]
	input  wire logic [2:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// read_data[15:0], clocks_on[23:16]
	output logic [23:0]      m_tdata,
	// error[0]
	output logic [0:0]       m_tuser
);

	localparam int AW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

	item_t       item_in;
	item_t       item_s1;
	logic        s1_valid_q;
	logic        accept;
	logic        advance;
	logic        in_port_ok;
	port_word_t  ram_rd;
	port_word_t  cur_word;
	port_word_t  new_word;
	port_word_t  fwd_word_q;
	logic        fwd_hit_s1;
	logic [15:0] read_data;
	logic [7:0]  clocks_next;
	ctl_t        ctl;
	logic        m_tvalid_q;
	logic [23:0] m_tdata_q;
	logic        m_err_q;

	assign item_in    = item_t'({s_tdata[ITEM_W-4:0], s_tuser});
	assign in_port_ok = 5'(item_in.port) < 5'(NUM_PORTS);

	// Pipeline handshake: stage one moves on when the output register is free.
	assign advance  = s1_valid_q && (!m_tvalid_q || m_tready);
	assign s_tready = !s1_valid_q || advance;
	assign accept   = s_tvalid && s_tready;

	gpre_port_ram #(
		.DEPTH (NUM_PORTS),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept && in_port_ok),
		.rd_addr (AW'(item_in.port)),
		.rd_data (ram_rd),
		.wr_en   (advance && ctl.wr_en),
		.wr_addr (AW'(item_s1.port)),
		.wr_data (new_word)
	);

	// A word written back in the cycle of the read overrides the memory data.
	assign cur_word = fwd_hit_s1 ? fwd_word_q : ram_rd;

	gpre_cmd_exec #(
		.NUM_PORTS     (NUM_PORTS),
		.PINS_PER_PORT (PINS_PER_PORT)
	) u_exec (
		.item      (item_s1),
		.cur_word  (cur_word),
		.new_word  (new_word),
		.read_data (read_data),
		.ctl       (ctl)
	);

	gpre_exti u_exti (
		.clk         (clk),
		.arst_n      (arst_n),
		.upd         (advance),
		.ctl         (ctl),
		.item        (item_s1),
		.clocks_next (clocks_next)
	);

	// Stage one payload and forwarded word.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1    <= item_in;
			fwd_word_q <= new_word;
		end
	end

	// Stage one control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			fwd_hit_s1 <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
				fwd_hit_s1 <= advance && ctl.wr_en && (item_in.port == item_s1.port);
			end else if (advance) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			m_tdata_q <= {clocks_next, read_data};
			m_err_q   <= ctl.err;
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (advance) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;
	assign m_tuser[0] = m_err_q;

endmodule

`default_nettype wire

// ----- rtl/core/gpre_port_ram.sv -----
// ----------------------------------------------------------------------------
// GPIO port register memory
// One word per port, one registered read port and one write port. Per-entry
// valid bits make never-written entries read as zero after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module gpre_port_ram
	import gpre_pkg::*;
#(
	parameter int DEPTH = 8,
	parameter int AW    = 3
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output port_word_t      rd_data,
	input  wire logic       wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire port_word_t wr_data
);

	port_word_t mem [DEPTH];
	port_word_t rd_word_q;
	logic [DEPTH-1:0] vld_q;
	logic rd_vld_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read of the word.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_word_q <= mem[rd_addr];
		end
	end

	// Valid bits and the registered valid flag of the read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_word_q : '0;

endmodule

`default_nettype wire

// ----- rtl/core/gpre_cmd_exec.sv -----
// ----------------------------------------------------------------------------
// GPIO port command unit
// Decodes one command against its port word: builds the new word, the read
// levels and the control group for write-back, clocks and line routing.
// ----------------------------------------------------------------------------
`default_nettype none

module gpre_cmd_exec
	import gpre_pkg::*;
#(
	parameter int NUM_PORTS     = 8,
	parameter int PINS_PER_PORT = 16
) (
	input  wire item_t      item,
	input  wire port_word_t cur_word,
	output port_word_t  new_word,
	output logic [15:0] read_data,
	output ctl_t        ctl
);

	localparam logic [15:0] PIN_MASK = 16'((17'd1 << PINS_PER_PORT) - 17'd1);

	logic        port_ok;
	logic        pin_ok;
	logic [4:0]  idx2;
	logic [5:0]  idx4;
	logic [15:0] out_mode;
	logic [15:0] set_mask;

	assign port_ok  = 5'(item.port) < 5'(NUM_PORTS);
	assign pin_ok   = 5'(item.pin) < 5'(PINS_PER_PORT);
	assign idx2     = {item.pin, 1'b0};
	assign idx4     = {item.pin, 2'b00};
	assign set_mask = item.mask & PIN_MASK;

	// Pins in output mode read back their latch.
	always_comb begin
		for (int i = 0; i < 16; i++) begin
			out_mode[i] = (cur_word.mode[2*i +: 2] == MODE_OUTPUT);
		end
	end

	// Command decode and register update.
	always_comb begin
		new_word   = cur_word;
		read_data  = '0;
		ctl        = '0;
		ctl.err    = !port_ok;
		case (item.cmd)
			CMD_GET: begin
				if (port_ok) begin
					read_data = ((cur_word.out_levels & out_mode) |
						(item.value & ~out_mode)) & PIN_MASK;
				end
			end
			CMD_SET: begin
				if (port_ok) begin
					new_word.out_levels = (cur_word.out_levels & ~set_mask) |
						(item.value & set_mask);
					ctl.wr_en = 1'b1;
				end
			end
			CMD_CONFIG: begin
				if (port_ok) begin
					ctl.clk_en = 1'b1;
					if (pin_ok) begin
						new_word.mode[idx2 +: 2]    = item.mode;
						new_word.otype[item.pin]    = item.open_drain;
						new_word.speed[idx2 +: 2]   = item.speed;
						new_word.pull[idx2 +: 2]    = item.pull;
						new_word.altfunc[idx4 +: 4] = item.alt_func;
						ctl.wr_en = 1'b1;
					end
				end
			end
			CMD_IRQ: begin
				if (port_ok) begin
					ctl.clk_en = 1'b1;
					ctl.irq_en = 1'b1;
				end
			end
			CMD_DELAY: begin
				new_word = cur_word;
			end
			default: begin
				ctl.err = 1'b1;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- rtl/core/gpre_exti.sv -----
// ----------------------------------------------------------------------------
// GPIO clock enable and external line router
// Holds the port clock enables and the per-line source, mask and edge
// trigger registers.
// ----------------------------------------------------------------------------
`default_nettype none

module gpre_exti
	import gpre_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  upd,
	input  wire ctl_t  ctl,
	input  wire item_t item,
	output logic [7:0] clocks_next
);

	logic [7:0]  clk_en_q;
	logic [3:0]  line_source_q [16];
	logic [15:0] line_mask_q;
	logic [15:0] rise_trigger_q;
	logic [15:0] fall_trigger_q;

	// Clock enables after the current command.
	assign clocks_next = ctl.clk_en ?
		(clk_en_q | (8'd1 << CLK_BIT_OF_PORT[item.port])) : clk_en_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clk_en_q       <= '0;
			line_mask_q    <= '0;
			rise_trigger_q <= '0;
			fall_trigger_q <= '0;
			for (int i = 0; i < 16; i++) begin
				line_source_q[i] <= '0;
			end
		end else if (upd) begin
			clk_en_q <= clocks_next;
			if (ctl.irq_en) begin
				line_source_q[item.pin] <= 4'(item.port);
				line_mask_q[item.pin]   <= item.irq_enable;
				if (item.rising_edge) begin
					rise_trigger_q[item.pin] <= item.irq_enable;
				end else begin
					fall_trigger_q[item.pin] <= item.irq_enable;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/gpre_checker.sv -----
// ----------------------------------------------------------------------------
// GPIO port engine checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module gpre_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [23:0] m_tdata,
	input wire logic [0:0]  m_tuser
);

	// No result is offered once reset has been seen at a clock edge.
	`ASSERT_CLK_ALWAYS(a_no_result_in_reset, !arst_n |=> !m_tvalid, "result valid during reset")

	// A stalled result keeps its payload.
	`ASSERT_CLK(a_stall_holds, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)), "stalled result changed")

	// A rejected command never returns pin levels.
	`ASSERT_CLK(a_error_no_data, (m_tvalid && m_tuser[0]) |-> (m_tdata[15:0] == 16'd0), "error result carries read data")

	// Port clocks are only ever switched on.
	`ASSERT_CLK(a_clocks_grow, (m_tvalid && m_tready) ##1 m_tvalid |-> ((m_tdata[23:16] & $past(m_tdata[23:16])) == $past(m_tdata[23:16])), "clock enable bit was lost")

endmodule

bind gpio_port_register_engine_core gpre_checker u_gpre_checker (.*);

`default_nettype wire
